[rtl/prrl_pkg.sv]
package prrl_pkg;

    // request kinds
    typedef enum logic [1:0] {
        KIND_PUBLISH = 2'd0,
        KIND_VIEW    = 2'd1,
        KIND_RECLAIM = 2'd2,
        KIND_UNUSED  = 2'd3
    } t_kind;

    // result status codes
    typedef enum logic [2:0] {
        STS_OK          = 3'd0,
        STS_CLOSED      = 3'd1,
        STS_BAD_SIZE    = 3'd2,
        STS_FULL        = 3'd3,
        STS_EXHAUSTED   = 3'd4,
        STS_RECLAIMED   = 3'd5,
        STS_UNPUBLISHED = 3'd6,
        STS_BAD_POS     = 3'd7
    } t_status;

    // sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_DIV,
        S_READ,
        S_EMIT
    } t_state;

    // configuration register indexes
    localparam logic [1:0] CFG_ENABLED      = 2'd0;
    localparam logic [1:0] CFG_CAPACITY     = 2'd1;
    localparam logic [1:0] CFG_RECORD_BYTES = 2'd2;

    localparam int CFG_DATA_W = 9;

    localparam logic [8:0] CAPACITY_RST     = 9'd256;
    localparam logic [3:0] RECORD_BYTES_RST = 4'd8;

endpackage

[rtl/positioned_record_ring_log.sv]
// Channel  | Direction | Handshake                  | Payload
// ---------+-----------+----------------------------+-------------------------------------
// in       | request   | i_in_valid / o_in_stall    | i_kind, i_position, i_payload_bytes,
//          |           |                            | i_payload
// out      | result    | o_out_valid / i_out_stall  | o_status, o_result_position,
//          |           |                            | o_record_data, o_head_now, o_tail_now
// cfg      | write     | i_cfg_valid / o_cfg_ready  | i_cfg_index, i_cfg_data
//
// One request is in flight at a time. Publish, reclaim and failing views pass
// through accept, execute and emit. A view that hits a live record adds a
// remainder state and a memory read state before emit: the slot is position
// modulo capacity, found by a restoring remainder that retires one dividend
// bit per cycle, followed by a synchronous record memory read.
// Reset (i_rst_n low, synchronous) closes the log, sets capacity 256 and
// record length 8, and clears head, tail and write slot; the record memory is
// not cleared. A finished result sits in the output register while the next
// request is accepted; a stalled output holds the sequencer in its emit state.
module positioned_record_ring_log
    import prrl_pkg::*;
#(
    parameter int DEPTH         = 256,
    parameter int RECORD_BITS   = 64,
    parameter int POSITION_BITS = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,

    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [1:0]            i_kind,
    input  logic [31:0]           i_position,
    input  logic [3:0]            i_payload_bytes,
    input  logic [63:0]           i_payload,

    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [2:0]            o_status,
    output logic [31:0]           o_result_position,
    output logic [63:0]           o_record_data,
    output logic [31:0]           o_head_now,
    output logic [31:0]           o_tail_now,

    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [1:0]            i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int PB        = POSITION_BITS;
    localparam int SLOT_W    = $clog2(DEPTH);
    localparam int CAP_W     = $clog2(DEPTH + 1);
    localparam int SLOT_CMPW = CAP_W + 1;
    localparam int DIFF_W    = PB + CAP_W;
    localparam int CNT_W     = $clog2(PB);
    localparam int MAX_BYTES = RECORD_BITS / 8;

    // ------------------------------------------------------------------
    // state
    // ------------------------------------------------------------------
    t_state                 r_state, n_state;

    logic                   r_enabled;
    logic [8:0]             r_capacity;
    logic [3:0]             r_record_bytes;
    logic [PB-1:0]          r_head;
    logic [PB-1:0]          r_tail;
    logic [SLOT_W-1:0]      r_wslot;

    // latched request
    t_kind                  r_kind;
    logic [PB-1:0]          r_pos;      // doubles as the dividend shifter
    logic [3:0]             r_plen;
    logic [RECORD_BITS-1:0] r_payload;

    // pending result
    t_status                r_p_status;
    logic [PB-1:0]          r_p_rpos;
    logic                   r_p_view;

    // remainder unit
    logic [CAP_W-1:0]       r_rem;
    logic [CNT_W-1:0]       r_cnt;

    // record memory
    logic [RECORD_BITS-1:0] r_mem [DEPTH];
    logic [RECORD_BITS-1:0] r_rd_data;

    // output register
    logic                   r_out_valid;
    t_status                r_out_status;
    logic [31:0]            r_out_rpos;
    logic [63:0]            r_out_data;
    logic [31:0]            r_out_head;
    logic [31:0]            r_out_tail;

    // ------------------------------------------------------------------
    // handshakes and control
    // ------------------------------------------------------------------
    logic in_acc, cfg_we, emit_load, mem_we, mem_re, div_step, exec_en;

    assign o_cfg_ready = 1'b1;
    assign cfg_we      = i_cfg_valid && o_cfg_ready;

    // capacity as used: 0 acts as 1, above DEPTH acts as DEPTH
    logic [CAP_W-1:0] live_cap;
    always_comb begin
        if (r_capacity == '0) begin
            live_cap = CAP_W'(1);
        end else if (int'(r_capacity) > DEPTH) begin
            live_cap = CAP_W'(DEPTH);
        end else begin
            live_cap = CAP_W'(r_capacity);
        end
    end

    // ------------------------------------------------------------------
    // execute decode (state S_EXEC)
    // ------------------------------------------------------------------
    t_status        x_status;
    logic [PB-1:0]  x_rpos;
    logic           x_pub, x_rcl, x_view;
    logic           bad_size, is_full, is_exh;
    logic [PB-1:0]  fill;

    assign fill     = r_head - r_tail;
    assign is_full  = DIFF_W'(fill) >= DIFF_W'(live_cap);
    assign is_exh   = r_head == {PB{1'b1}};
    assign bad_size = (r_record_bytes == '0) || (int'(r_record_bytes) > MAX_BYTES)
                      || (r_plen != r_record_bytes);

    always_comb begin
        x_status = STS_OK;
        x_rpos   = '0;
        x_pub    = 1'b0;
        x_rcl    = 1'b0;
        x_view   = 1'b0;
        if (r_kind == KIND_UNUSED) begin
            x_status = STS_BAD_POS;
        end else if (!r_enabled) begin
            x_status = STS_CLOSED;
        end else begin
            unique case (r_kind)
                KIND_PUBLISH: begin
                    if (bad_size) begin
                        x_status = STS_BAD_SIZE;
                    end else if (is_full) begin
                        x_status = STS_FULL;
                    end else if (is_exh) begin
                        x_status = STS_EXHAUSTED;
                    end else begin
                        x_pub  = 1'b1;
                        x_rpos = r_head;
                    end
                end
                KIND_VIEW: begin
                    if (r_pos < r_tail) begin
                        x_status = STS_RECLAIMED;
                    end else if (r_pos >= r_head) begin
                        x_status = STS_UNPUBLISHED;
                    end else begin
                        x_view = 1'b1;
                        x_rpos = r_pos;
                    end
                end
                KIND_RECLAIM: begin
                    if (r_pos < r_tail || r_pos > r_head) begin
                        x_status = STS_BAD_POS;
                    end else begin
                        x_rcl = 1'b1;
                    end
                end
                default: x_status = STS_BAD_POS;
            endcase
        end
    end

    // payload trimmed to the configured record length
    logic [RECORD_BITS-1:0] store_data;
    always_comb begin
        for (int k = 0; k < RECORD_BITS; k++) begin
            store_data[k] = r_payload[k] && (k < 8 * int'(r_record_bytes));
        end
    end

    // write slot advance, wraps at capacity
    logic [SLOT_W-1:0] wslot_next;
    always_comb begin
        if (SLOT_CMPW'(r_wslot) + SLOT_CMPW'(1) >= SLOT_CMPW'(live_cap)) begin
            wslot_next = '0;
        end else begin
            wslot_next = r_wslot + SLOT_W'(1);
        end
    end

    // one restoring remainder step
    logic [CAP_W:0]   rem_trial;
    logic [CAP_W-1:0] rem_next;
    assign rem_trial = {r_rem, r_pos[PB-1]};
    always_comb begin
        if (rem_trial >= {1'b0, live_cap}) begin
            rem_next = CAP_W'(rem_trial - {1'b0, live_cap});
        end else begin
            rem_next = CAP_W'(rem_trial);
        end
    end

    // ------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (i_in_valid) n_state = S_EXEC;
            S_EXEC: n_state = x_view ? S_DIV : S_EMIT;
            S_DIV:  if (r_cnt == '0) n_state = S_READ;
            S_READ: n_state = S_EMIT;
            S_EMIT: if (!r_out_valid || !i_out_stall) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_in_stall = 1'b1;
        exec_en    = 1'b0;
        div_step   = 1'b0;
        mem_re     = 1'b0;
        emit_load  = 1'b0;
        unique case (r_state)
            S_IDLE: o_in_stall = 1'b0;
            S_EXEC: exec_en    = 1'b1;
            S_DIV:  div_step   = 1'b1;
            S_READ: mem_re     = 1'b1;
            S_EMIT: emit_load  = !r_out_valid || !i_out_stall;
            default: o_in_stall = 1'b1;
        endcase
    end

    assign in_acc = i_in_valid && !o_in_stall;
    assign mem_we = exec_en && x_pub;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // ------------------------------------------------------------------
    // configuration and log pointers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enabled      <= 1'b0;
            r_capacity     <= CAPACITY_RST;
            r_record_bytes <= RECORD_BYTES_RST;
            r_head         <= '0;
            r_tail         <= '0;
            r_wslot        <= '0;
        end else if (cfg_we) begin
            unique case (i_cfg_index)
                CFG_ENABLED: begin
                    if (i_cfg_data[0] && !r_enabled) begin
                        r_head  <= '0;
                        r_tail  <= '0;
                        r_wslot <= '0;
                    end
                    r_enabled <= i_cfg_data[0];
                end
                CFG_CAPACITY:     r_capacity     <= i_cfg_data[8:0];
                CFG_RECORD_BYTES: r_record_bytes <= i_cfg_data[3:0];
                default: ;
            endcase
        end else if (exec_en) begin
            if (x_pub) begin
                r_head  <= r_head + PB'(1);
                r_wslot <= wslot_next;
            end
            if (x_rcl) begin
                r_tail <= r_pos;
            end
        end
    end

    // ------------------------------------------------------------------
    // request latch, pending result, remainder unit
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_kind    <= t_kind'(i_kind);
            r_pos     <= PB'(i_position);
            r_plen    <= i_payload_bytes;
            r_payload <= RECORD_BITS'(i_payload);
        end else if (div_step) begin
            r_pos <= {r_pos[PB-2:0], 1'b0};
        end
        if (exec_en) begin
            r_p_status <= x_status;
            r_p_rpos   <= x_rpos;
            r_p_view   <= x_view;
            r_rem      <= '0;
            r_cnt      <= CNT_W'(PB - 1);
        end else if (div_step) begin
            r_rem <= rem_next;
            r_cnt <= r_cnt - CNT_W'(1);
        end
    end

    // ------------------------------------------------------------------
    // record memory: one write port, one registered read port
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_wslot] <= store_data;
        end
        if (mem_re) begin
            r_rd_data <= r_mem[SLOT_W'(r_rem)];
        end
    end

    // ------------------------------------------------------------------
    // output register
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit_load) begin
            r_out_status <= r_p_status;
            r_out_rpos   <= 32'(r_p_rpos);
            r_out_data   <= r_p_view ? 64'(r_rd_data) : 64'h0;
            r_out_head   <= 32'(r_head);
            r_out_tail   <= 32'(r_tail);
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_status          = r_out_status;
    assign o_result_position = r_out_rpos;
    assign o_record_data     = r_out_data;
    assign o_head_now        = r_out_head;
    assign o_tail_now        = r_out_tail;

    // ------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------
    a_tail_le_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tail <= r_head)
        else $error("tail passed head");

    a_wslot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_wslot) < DEPTH)
        else $error("write slot out of memory range");

    a_rem_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ) |-> (r_rem < live_cap))
        else $error("slot remainder not below capacity");

    a_pub_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (mem_we && !cfg_we) |=> (r_head == $past(r_head) + PB'(1)))
        else $error("publish did not advance head");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (o_in_stall && !emit_load))
        else $error("sequencer not busy after accepting a request");

endmodule
